// File: src/vrt_pkg.sv
// Package for the voxel ray walk: beat structs, widths, shared constants.
// No dependencies.
package vrt_pkg;

  localparam int RL_W = 17;
  localparam int T_W = 32;
  localparam int MAX_CELLS_DEF = 64;
  localparam logic [RL_W-1:0] REACH_RESET = 17'd20480;

  localparam logic [1:0] FACE_NONE = 2'd0;
  localparam logic [1:0] FACE_X = 2'd1;
  localparam logic [1:0] FACE_Y = 2'd2;
  localparam logic [1:0] FACE_Z = 2'd3;

  // divider jobs: spacing for x, y, z, then first crossing for x, y, z
  localparam logic [2:0] JOB_FIRST = 3'd3;
  localparam logic [2:0] JOB_END = 3'd6;

  localparam logic [4:0] ROOT_STEPS = 5'd17;
  localparam logic [4:0] DIV_STEPS = 5'd29;

  typedef struct packed {
    logic signed [23:0] origin_x;
    logic signed [23:0] origin_y;
    logic signed [23:0] origin_z;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
  } ray_t;

  typedef struct packed {
    logic signed [11:0] cell_x;
    logic signed [11:0] cell_y;
    logic signed [11:0] cell_z;
    logic [16:0] entry_param;
    logic [1:0] face_axis;
    logic face_negative;
    logic no_ray;
    logic last_cell;
  } cell_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture ray
    logic sqr_step;  // accumulate one axis squared
    logic root_init;
    logic root_step;
    logic div_init;  // start divider on job sel
    logic div_step;
    logic div_store;
    logic [2:0] div_sel;
    logic emit_first;
    logic emit_zero;
    logic walk_step;
    logic walk_end;
  } vrt_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic zero_dir;
    logic root_done;
    logic div_done;
    logic axis_zero;   // direction for div_sel axis is zero
    logic reach_over;  // next crossing beyond reach
  } vrt_sts_t;

endpackage

// File: src/vrt_ctrl.sv
// Controller state machine for the voxel ray walk.
// Depends on vrt_pkg.
module vrt_ctrl
  import vrt_pkg::*;
#(
  parameter int MAX_CELLS = MAX_CELLS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  vrt_sts_t sts,
  output vrt_cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SQR  = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_ROOT = 3'd3;
  localparam logic [2:0] S_DSEL = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_WALK = 3'd6;
  localparam int CW = $clog2(MAX_CELLS + 1);

  logic [2:0] state, state_next;
  logic [1:0] sq_cnt;
  logic [2:0] job;
  logic [CW-1:0] n;

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.div_sel = job;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_next = S_SQR;
        end
      end
      S_SQR: begin
        cmd.sqr_step = 1'b1;
        if (sq_cnt == 2'd2) begin
          state_next = S_CHK;
        end
      end
      S_CHK: begin
        if (sts.zero_dir) begin
          cmd.emit_zero = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.root_init = 1'b1;
          state_next = S_ROOT;
        end
      end
      S_ROOT: begin
        if (sts.root_done) begin
          state_next = S_DSEL;
        end else begin
          cmd.root_step = 1'b1;
        end
      end
      S_DSEL: begin
        if (job == JOB_END) begin
          cmd.emit_first = 1'b1;
          state_next = S_WALK;
        end else if (!sts.axis_zero) begin
          cmd.div_init = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.div_store = 1'b1;
          state_next = S_DSEL;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_WALK: begin
        if (sts.reach_over || n == CW'(MAX_CELLS)) begin
          cmd.walk_end = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sq_cnt <= '0;
      job <= '0;
      n <= '0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        sq_cnt <= '0;
      end else if (cmd.sqr_step) begin
        sq_cnt <= sq_cnt + 2'd1;
      end
      if (cmd.root_init) begin
        job <= '0;
      end else if (cmd.div_store || (state == S_DSEL && job != JOB_END && sts.axis_zero)) begin
        job <= job + 3'd1;
      end
      if (cmd.emit_first) begin
        n <= CW'(1);
      end else if (cmd.walk_step) begin
        n <= n + CW'(1);
      end
    end
  end

endmodule

// File: src/vrt_dp.sv
// Datapath for the voxel ray walk: square sum, bit-serial root and divider,
// crossing registers, pending beat and the emit register. Depends on vrt_pkg.
module vrt_dp
  import vrt_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  ray_t            ray,
  input  logic [RL_W-1:0] reach_limit,
  input  vrt_cmd_t        cmd,
  output vrt_sts_t        sts,
  output cell_t           result,
  output logic            result_valid
);

  ray_t r;
  logic [33:0] sq;
  logic [1:0] sq_idx;
  logic [33:0] rv;
  logic [17:0] rr;
  logic [19:0] rrem;
  logic [4:0] rcnt;
  logic [15:0] ln;

  logic [15:0] rem;
  logic [28:0] quo;
  logic [15:0] dvs;
  logic [4:0] dcnt;

  logic [11:0] vox [3];
  logic [T_W-1:0] nxt [3];
  logic [T_W-1:0] spc [3];
  logic [2:0] pos;
  cell_t pend;

  logic signed [15:0] dsq;
  logic signed [31:0] dsq2;
  logic signed [15:0] dsel;
  logic [1:0] jax;
  logic [12:0] gap;
  logic [28:0] num;
  logic [1:0] ax;
  logic [T_W:0] nsum;
  logic [11:0] vstep;
  logic [19:0] rtrial;
  logic [16:0] dsh;
  logic [17:0] dtry;
  cell_t pend_last;
  cell_t step_beat;

  assign ln = rr[15:0];

  always_comb begin
    case (sq_idx)
      2'd0: dsq = r.dir_x;
      2'd1: dsq = r.dir_y;
      default: dsq = r.dir_z;
    endcase
    dsq2 = dsq * dsq;
    jax = (cmd.div_sel >= JOB_FIRST) ? 2'(cmd.div_sel - JOB_FIRST) : cmd.div_sel[1:0];
    case (jax)
      2'd0: dsel = r.dir_x;
      2'd1: dsel = r.dir_y;
      default: dsel = r.dir_z;
    endcase
    case (jax)
      2'd0: gap = r.dir_x[15] ? {1'b0, r.origin_x[11:0]} : 13'd4096 - {1'b0, r.origin_x[11:0]};
      2'd1: gap = r.dir_y[15] ? {1'b0, r.origin_y[11:0]} : 13'd4096 - {1'b0, r.origin_y[11:0]};
      default: gap = r.dir_z[15] ? {1'b0, r.origin_z[11:0]} : 13'd4096 - {1'b0, r.origin_z[11:0]};
    endcase
    num = {16'd0, gap} * {13'd0, ln};
    ax = 2'd0;
    if (nxt[1] < nxt[0]) ax = 2'd1;
    if (nxt[2] < nxt[ax]) ax = 2'd2;
    nsum = {1'b0, nxt[ax]} + {1'b0, spc[ax]};
    vstep = pos[ax] ? vox[ax] + 12'd1 : vox[ax] - 12'd1;
    rtrial = {rrem[17:0], rv[33:32]};
    dsh = {rem, quo[28]};
    dtry = {1'b0, dsh} - {2'b00, dvs};
    pend_last = pend;
    pend_last.last_cell = 1'b1;
    step_beat.cell_x = (ax == 2'd0) ? vstep : vox[0];
    step_beat.cell_y = (ax == 2'd1) ? vstep : vox[1];
    step_beat.cell_z = (ax == 2'd2) ? vstep : vox[2];
    step_beat.entry_param = nxt[ax][16:0];
    step_beat.face_axis = ax + 2'd1;
    step_beat.face_negative = pos[ax];
    step_beat.no_ray = 1'b0;
    step_beat.last_cell = 1'b0;
  end

  assign sts.zero_dir = (sq == '0);
  assign sts.root_done = (rcnt == ROOT_STEPS);
  assign sts.div_done = (dcnt == DIV_STEPS);
  assign sts.axis_zero = (dsel == '0);
  assign sts.reach_over = (nxt[ax] > {{(T_W-RL_W){1'b0}}, reach_limit});

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      for (int a = 0; a < 3; a++) begin
        nxt[a] <= '1;
        spc[a] <= '1;
        vox[a] <= '0;
      end
      sq <= '0;
    end else begin
      result_valid <= cmd.emit_zero || cmd.walk_step || cmd.walk_end;
      if (cmd.load) begin
        r <= ray;
        sq <= '0;
        sq_idx <= '0;
      end
      if (cmd.sqr_step) begin
        sq <= sq + {2'd0, dsq2};
        sq_idx <= sq_idx + 2'd1;
      end
      if (cmd.root_init) begin
        rv <= sq;
        rr <= '0;
        rrem <= '0;
        rcnt <= '0;
        vox[0] <= r.origin_x[23:12];
        vox[1] <= r.origin_y[23:12];
        vox[2] <= r.origin_z[23:12];
        pos <= {~r.dir_z[15], ~r.dir_y[15], ~r.dir_x[15]};
        for (int a = 0; a < 3; a++) begin
          nxt[a] <= '1;
          spc[a] <= '1;
        end
      end
      // restoring root, two bits of radicand per step
      if (cmd.root_step) begin
        rv <= {rv[31:0], 2'b00};
        rcnt <= rcnt + 5'd1;
        if (rtrial >= {rr, 2'b01}) begin
          rrem <= rtrial - {rr, 2'b01};
          rr <= {rr[16:0], 1'b1};
        end else begin
          rrem <= rtrial;
          rr <= {rr[16:0], 1'b0};
        end
      end
      if (cmd.div_init) begin
        dvs <= dsel[15] ? 16'(-dsel) : 16'(dsel);
        rem <= '0;
        dcnt <= '0;
        quo <= (cmd.div_sel < JOB_FIRST) ? {1'b0, ln, 12'd0} : num;
      end
      if (cmd.div_step) begin
        dcnt <= dcnt + 5'd1;
        if (!dtry[17]) begin
          rem <= dtry[15:0];
          quo <= {quo[27:0], 1'b1};
        end else begin
          rem <= dsh[15:0];
          quo <= {quo[27:0], 1'b0};
        end
      end
      if (cmd.div_store) begin
        if (cmd.div_sel < JOB_FIRST) spc[jax] <= {{(T_W-29){1'b0}}, quo};
        else nxt[jax] <= {{(T_W-29){1'b0}}, quo};
      end
      if (cmd.emit_zero) begin
        result <= '{12'd0, 12'd0, 12'd0, 17'd0, FACE_NONE, 1'b0, 1'b1, 1'b1};
      end
      // origin beat waits in pend until the walk knows whether it is final
      if (cmd.emit_first) begin
        pend <= '{vox[0], vox[1], vox[2], 17'd0, FACE_NONE, 1'b0, 1'b0, 1'b0};
      end
      if (cmd.walk_step) begin
        vox[ax] <= vstep;
        nxt[ax] <= nsum[T_W] ? '1 : nsum[T_W-1:0];
        result <= pend;
        pend <= step_beat;
      end
      if (cmd.walk_end) begin
        result <= pend_last;
      end
    end
  end

endmodule

// File: src/voxel_ray_traversal.sv
// Voxel ray walk (3D DDA) top level. Depends on vrt_pkg, vrt_ctrl, vrt_dp.
// A zero direction ray gives a single beat, flagged no_ray and last; otherwise
// the square sum, the root and the divides run in turn (the divides for a zero
// direction axis are skipped), then one beat per cycle, the final one flagged last.
// A new ray is taken only while idle; busy stays high until the last beat.
// Reset: synchronous, clears control, crossings and reach_limit to 20480.
module voxel_ray_traversal
  import vrt_pkg::*;
#(
  parameter int MAX_CELLS = MAX_CELLS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  ray_t            ray,
  input  logic            cfg_we,
  input  logic [RL_W-1:0] cfg_data,
  output logic            valid,
  output cell_t           result
);

  logic [RL_W-1:0] reach_limit;
  vrt_cmd_t cmd;
  vrt_sts_t sts;

  always_ff @(posedge clk) begin
    if (rst) begin
      reach_limit <= REACH_RESET;
    end else if (cfg_we) begin
      reach_limit <= cfg_data;
    end
  end

  vrt_ctrl #(.MAX_CELLS(MAX_CELLS)) u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .sts(sts), .cmd(cmd)
  );

  vrt_dp u_dp (
    .clk(clk), .rst(rst), .ray(ray), .reach_limit(reach_limit), .cmd(cmd),
    .sts(sts), .result(result), .result_valid(valid)
  );

`ifndef SYNTHESIS
  a_run: assert property (@(posedge clk) disable iff (rst)
    (valid && !result.last_cell) |=> valid) else $error("gap inside a walk");
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (valid && result.last_cell) |=> !valid) else $error("beat after last");
  a_noray: assert property (@(posedge clk) disable iff (rst)
    (valid && result.no_ray) |-> result.last_cell) else $error("no_ray not last");
  a_origin: assert property (@(posedge clk) disable iff (rst)
    (valid && result.face_axis == FACE_NONE && !result.no_ray) |-> (result.entry_param == '0))
    else $error("origin beat with entry");
`endif

endmodule

// File: sim/testbench.sv
// Self-checking bench for voxel_ray_traversal: drives rays, predicts every
// emitted cell beat and compares them in order. Depends on vrt_pkg and the RTL.
module testbench;
  import vrt_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  ray_t ray = '0;
  logic cfg_we = 1'b0;
  logic [RL_W-1:0] cfg_data = '0;
  logic valid;
  cell_t result;

  voxel_ray_traversal dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .ray(ray),
    .cfg_we(cfg_we), .cfg_data(cfg_data), .valid(valid), .result(result)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  ray_t rays_pending[$];
  cell_t cells_due[$];
  logic [RL_W-1:0] reach;
  logic busy_at_edge;
  int sender_idle_pct = 0;
  int failures = 0;
  int cycle = 0;

  function automatic logic [31:0] isqrt(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r[31:0];
  endfunction

  task automatic predict_walk(ray_t r);
    logic signed [23:0] org [3];
    logic signed [15:0] dir [3];
    logic [11:0] vox [3];
    logic [31:0] tnext [3], tstep [3];
    logic [63:0] sq, ad, gap, nx;
    logic [31:0] len, t;
    int n, ax;
    cell_t c;
    org = '{r.origin_x, r.origin_y, r.origin_z};
    dir = '{r.dir_x, r.dir_y, r.dir_z};
    sq = 0;
    for (int a = 0; a < 3; a++) sq += 64'($signed(dir[a]) * $signed(dir[a]));
    if (sq == 0) begin
      c = '0;
      c.no_ray = 1'b1;
      c.last_cell = 1'b1;
      cells_due.push_back(c);
      return;
    end
    len = isqrt(sq);
    for (int a = 0; a < 3; a++) begin
      vox[a] = org[a][23:12];
      tnext[a] = '1;
      tstep[a] = '1;
      if (dir[a] != 0) begin
        if (dir[a] > 0) begin
          ad = 64'(dir[a]);
          gap = 64'd4096 - org[a][11:0];
        end else begin
          ad = 64'(-32'(dir[a]));
          gap = 64'(org[a][11:0]);
        end
        tstep[a] = 32'((64'(len) << 12) / ad);
        tnext[a] = 32'((gap * len) / ad);
      end
    end
    c = '0;
    c.cell_x = vox[0];
    c.cell_y = vox[1];
    c.cell_z = vox[2];
    n = 1;
    while (n < MAX_CELLS_DEF) begin
      ax = 0;
      if (tnext[1] < tnext[ax]) ax = 1;
      if (tnext[2] < tnext[ax]) ax = 2;
      t = tnext[ax];
      if (t > 32'(reach)) break;
      cells_due.push_back(c);
      if (dir[ax] > 0) vox[ax] = vox[ax] + 1;
      else vox[ax] = vox[ax] - 1;
      nx = 64'(t) + tstep[ax];
      tnext[ax] = (nx > 64'hFFFFFFFF) ? '1 : nx[31:0];
      c = '0;
      c.cell_x = vox[0];
      c.cell_y = vox[1];
      c.cell_z = vox[2];
      c.entry_param = t[16:0];
      c.face_axis = (ax == 0) ? FACE_X : (ax == 1) ? FACE_Y : FACE_Z;
      c.face_negative = dir[ax] > 0;
      n++;
    end
    c.last_cell = 1'b1;
    cells_due.push_back(c);
  endtask

  // driver
  always @(negedge clk) begin
    if (!rst) begin
      if (start && !busy_at_edge) begin
        start <= 1'b0;
      end else if (!start && rays_pending.size() != 0 &&
                   $urandom_range(99) >= sender_idle_pct) begin
        ray <= rays_pending.pop_front();
        start <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    busy_at_edge <= busy;
    if (!rst && start && !busy) predict_walk(ray);
    if (!rst && valid) begin
      if (cells_due.size() == 0) begin
        $display("%0t: unexpected beat %p", $time, result);
        failures++;
      end else if (result !== cells_due[0]) begin
        $display("%0t: mismatch expected %p actual %p", $time, cells_due[0], result);
        failures++;
        void'(cells_due.pop_front());
      end else begin
        void'(cells_due.pop_front());
      end
    end
    if (cycle > 2000000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic ray_t rand_ray(bit aligned);
    ray_t r;
    r.origin_x = 24'($urandom);
    r.origin_y = 24'($urandom);
    r.origin_z = 24'($urandom);
    if (aligned) r.origin_y[11:0] = 12'h000;
    r.dir_x = 16'($urandom);
    r.dir_y = 16'($urandom);
    r.dir_z = 16'($urandom);
    case ($urandom_range(7))
      0: r.dir_x = 0;
      1: begin r.dir_y = 0; r.dir_z = 0; end
      2: r.dir_z = 16'($signed(16'($urandom_range(40))) - 16'sd20);
      default: ;
    endcase
    return r;
  endfunction

  task automatic drain();
    while (rays_pending.size() != 0 || start || busy || cells_due.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_reach(logic [RL_W-1:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    reach = v;
  endtask

  initial begin
    reach = REACH_RESET;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // directed
    rays_pending.push_back('0);
    rays_pending.push_back('{24'sh7FFFFF, 24'sh800000, 0, 16'sh7FFF, 16'sh8000, 16'sh7FFF});
    rays_pending.push_back('{24'sh800000, 24'sh7FFFFF, 24'sh001000, 16'sh8000, 16'sh7FFF, 0});
    rays_pending.push_back('{24'sh002000, 24'sh003000, 24'sh004000, 16'sh8000, 0, 0});
    rays_pending.push_back('{24'sh000800, 24'sh000800, 24'sh000800, 16'sh4000, 16'sh4000, 16'sh4000});
    rays_pending.push_back('{24'sh7FF800, 24'sh000000, 24'sh000000, 16'sh0001, 0, 0});
    rays_pending.push_back('{24'sh000000, 24'sh000000, 24'sh000000, 0, 0, 16'shFFFF});
    rays_pending.push_back('{24'sh123456, 24'shFEDCBA, 24'sh000FFF, 16'sh0100, 16'sh0001, 0});
    drain();
    set_reach(17'd81920);
    sender_idle_pct = 18;
    for (int i = 0; i < 35; i++) rays_pending.push_back(rand_ray($urandom_range(3) == 0));
    drain();
    set_reach(17'h1FFFF);
    sender_idle_pct = 60;
    for (int i = 0; i < 25; i++) rays_pending.push_back(rand_ray($urandom_range(3) == 0));
    drain();
    set_reach(17'd0);
    sender_idle_pct = 0;
    for (int i = 0; i < 10; i++) rays_pending.push_back(rand_ray($urandom_range(1) == 0));
    drain();
    set_reach(17'($urandom_range(81920)));
    for (int i = 0; i < 30; i++) rays_pending.push_back(rand_ray($urandom_range(3) == 0));
    drain();
    if (failures == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule

// File: sim.f
src/vrt_pkg.sv
src/vrt_ctrl.sv
src/vrt_dp.sv
src/voxel_ray_traversal.sv
sim/testbench.sv
